// ----- hw/rtl/mrc_pkg.sv -----
`default_nettype none
package mrc_pkg;

  // Default sizes, handed down from the top level parameters
  localparam int FRAME_BYTES_DEF = 256;
  localparam int MAX_WORDS_DEF   = 63;

  // Port widths fixed by the field layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 32;
  localparam int TUSER_W    = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE    = 3'd4;

  // Modbus function codes and masks
  localparam logic [7:0] FN_READ_HOLDING = 8'd3;
  localparam logic [7:0] FN_READ_INPUT   = 8'd4;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'd16;
  localparam logic [7:0] CMD_MASK        = 8'h7F;
  localparam int         EXC_BIT         = 7;

  // CRC-16/MODBUS, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [3:0] {
    ST_DATA           = 4'd0,
    ST_READ_OK        = 4'd1,
    ST_WRITE_OK       = 4'd2,
    ST_TOO_SHORT      = 4'd3,
    ST_CRC_BAD        = 4'd4,
    ST_DEV_MISMATCH   = 4'd5,
    ST_FUNC_MISMATCH  = 4'd6,
    ST_COUNT_MISMATCH = 4'd7,
    ST_ACK_MISMATCH   = 4'd8,
    ST_EXCEPTION      = 4'd9
  } status_t;

  // One checked frame, as handed from front to back
  typedef struct packed {
    status_t    status;
    logic [7:0] exc_code;
    logic       closes;
    logic [5:0] words;
    logic       bank;
  } job_t;

  // Back tells front that a frame buffer bank is free again
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  typedef enum logic {
    FS_ACC,
    FS_CHK
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_RD_HI,
    BS_RD_LO,
    BS_WORD,
    BS_STATUS
  } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/modbus_rtu_reply_checker_top.sv -----
// Modbus RTU reply checker: one byte per cycle while a frame streams in; after the frame-end byte
// input holds in a check state until the job queue has room, and while the next bank is still walked.
// A status-only result follows the check; a good read first gives its data words, each from two
// byte reads and one output load, then the status item; any output stall holds the walk.
// Reset (sync, active high) clears frames, queue and output and loads register defaults.
`default_nettype none
module modbus_rtu_reply_checker_top #(
  parameter int FRAME_BYTES = mrc_pkg::FRAME_BYTES_DEF,
  parameter int MAX_WORDS   = mrc_pkg::MAX_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte stream in
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                           s_axis_tlast,   // end_of_frame
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data,
  // result stream out
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [7:0] exception_code, [23:8] data_word, [29:24] word_index, [30] closes_request,
  // [31] zero
  output logic [mrc_pkg::TDATA_W-1:0]         m_axis_tdata,
  output logic [mrc_pkg::TUSER_W-1:0]         m_axis_tuser,   // [3:0] status
  output logic                                m_axis_tlast    // last
);

  // Two banks of frame buffer: the front fills one while the back walks the other.
  localparam int PW        = $clog2(FRAME_BYTES);
  localparam int RAM_DEPTH = 2 ** (PW + 1);

  logic          mem_we;
  logic [PW:0]   mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [PW:0]   mem_raddr;
  logic [7:0]    mem_rdata;

  logic          job_push;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;
  mrc_pkg::job_t job_in;
  mrc_pkg::job_t job_out;
  mrc_pkg::done_t done;

  // Front: take bytes, store them, run the CRC, classify the frame at its end.
  mrc_front #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_WORDS  (MAX_WORDS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .job_push     (job_push),
    .job          (job_in),
    .job_full     (job_full),
    .done         (done)
  );

  // Hold up to two checked frames between front and back.
  mrc_job_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  (job_in),
    .full (job_full),
    .pop  (job_pop),
    .dout (job_out),
    .empty(job_empty)
  );

  mrc_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Back: emit the data words of a good read, then the status transaction; release the bank.
  mrc_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (job_empty),
    .job_pop      (job_pop),
    .job          (job_out),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .done         (done),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/mrc_ram.sv -----
`default_nettype none
module mrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mrc_job_fifo.sv -----
`default_nettype none
module mrc_job_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mrc_pkg::job_t din,
  output logic               full,
  input  wire logic          pop,
  output mrc_pkg::job_t      dout,
  output logic               empty
);

  mrc_pkg::job_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");

endmodule
`default_nettype wire

// ----- hw/rtl/mrc_front.sv -----
`default_nettype none
module mrc_front #(
  parameter int FRAME_BYTES = mrc_pkg::FRAME_BYTES_DEF,
  parameter int MAX_WORDS   = mrc_pkg::MAX_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   mem_we,
  output logic [$clog2(FRAME_BYTES):0]           mem_waddr,
  output logic [7:0]                             mem_wdata,
  output logic                                   job_push,
  output mrc_pkg::job_t                          job,
  input  wire logic                              job_full,
  input  wire mrc_pkg::done_t                    done
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int LW = CW + 9;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  mrc_pkg::front_state_t state, state_next;
  logic [CW-1:0] count;
  logic [15:0]   crc;
  logic          ovf;
  logic          bank;
  logic [1:0]    busy;
  logic [7:0]    hdr [6];

  logic [7:0]  exp_dev;
  logic [7:0]  exp_fn;
  logic [15:0] exp_reg;
  logic [5:0]  exp_cnt;
  logic [15:0] exp_val;

  logic        accept;
  logic        room;
  logic [7:0]  cmd;
  logic [6:0]  words;
  logic        is_read;
  logic        is_write;
  logic        short_read;
  logic [15:0] reg_echo;
  logic [15:0] want;
  logic        ack_ok;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign room   = (count < CW'(FRAME_BYTES));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrc_pkg::FS_ACC: begin
        if (accept && s_axis_tlast) begin
          state_next = mrc_pkg::FS_CHK;
        end
      end
      mrc_pkg::FS_CHK: begin
        if (!job_full) begin
          state_next = mrc_pkg::FS_ACC;
        end
      end
      default: state_next = mrc_pkg::FS_ACC;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    job_push      = 1'b0;
    case (state)
      mrc_pkg::FS_ACC: s_axis_tready = !busy[bank];
      mrc_pkg::FS_CHK: job_push      = !job_full;
      default: begin
        s_axis_tready = 1'b0;
        job_push      = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign mem_we    = accept && room;
  assign mem_waddr = {bank, count[PW-1:0]};
  assign mem_wdata = s_axis_tdata;

  // frame classification, in priority order
  always_comb begin
    cmd        = hdr[1] & mrc_pkg::CMD_MASK;
    words      = hdr[2][7:1];
    is_read    = (cmd == mrc_pkg::FN_READ_HOLDING) || (cmd == mrc_pkg::FN_READ_INPUT);
    is_write   = (cmd == mrc_pkg::FN_WRITE_SINGLE) || (cmd == mrc_pkg::FN_WRITE_MULTI);
    short_read = (LW'(count) < (LW'(5) + LW'({words, 1'b0})));
    reg_echo   = {hdr[2], hdr[3]} + 16'd1;
    want       = (cmd == mrc_pkg::FN_WRITE_SINGLE) ? exp_val : {10'd0, exp_cnt};
    ack_ok     = (count >= CW'(8)) && (reg_echo == exp_reg) && ({hdr[4], hdr[5]} == want);

    job.status   = mrc_pkg::ST_FUNC_MISMATCH;
    job.exc_code = 8'h00;
    job.closes   = 1'b1;
    job.words    = 6'd0;
    job.bank     = bank;

    if (count <= CW'(4)) begin
      job.status = mrc_pkg::ST_TOO_SHORT;
      job.closes = 1'b0;
    end else if (ovf || (crc != 16'h0000)) begin
      job.status = mrc_pkg::ST_CRC_BAD;
      job.closes = 1'b0;
    end else if (hdr[0] != exp_dev) begin
      job.status = mrc_pkg::ST_DEV_MISMATCH;
      job.closes = 1'b0;
    end else if (cmd != exp_fn) begin
      job.status = mrc_pkg::ST_FUNC_MISMATCH;
      job.closes = 1'b0;
    end else if (hdr[1][mrc_pkg::EXC_BIT]) begin
      job.status   = mrc_pkg::ST_EXCEPTION;
      job.exc_code = hdr[2];
    end else if (is_read) begin
      if ((words != {1'b0, exp_cnt}) || (words > 7'(MAX_WORDS)) || short_read) begin
        job.status = mrc_pkg::ST_COUNT_MISMATCH;
      end else begin
        job.status = mrc_pkg::ST_READ_OK;
        job.words  = words[5:0];
      end
    end else if (is_write) begin
      job.status = ack_ok ? mrc_pkg::ST_WRITE_OK : mrc_pkg::ST_ACK_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mrc_pkg::FS_ACC;
      count   <= '0;
      crc     <= mrc_pkg::CRC_INIT;
      ovf     <= 1'b0;
      bank    <= 1'b0;
      busy    <= 2'b00;
      exp_dev <= 8'd1;
      exp_fn  <= 8'd3;
      exp_reg <= 16'd1;
      exp_cnt <= 6'd1;
      exp_val <= 16'd0;
    end else begin
      state <= state_next;
      if (done.valid) begin
        busy[done.bank] <= 1'b0;
      end
      if (accept) begin
        if (room) begin
          count <= count + CW'(1);
          crc   <= crc_feed(crc, s_axis_tdata);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (job_push) begin
        count      <= '0;
        crc        <= mrc_pkg::CRC_INIT;
        ovf        <= 1'b0;
        bank       <= ~bank;
        busy[bank] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mrc_pkg::CFG_DEVICE:   exp_dev <= cfg_data[7:0];
          mrc_pkg::CFG_FUNCTION: exp_fn  <= cfg_data[7:0];
          mrc_pkg::CFG_REGISTER: exp_reg <= cfg_data;
          mrc_pkg::CFG_COUNT:    exp_cnt <= cfg_data[5:0];
          mrc_pkg::CFG_VALUE:    exp_val <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // header bytes kept beside the buffer for the frame-end check
  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      if (mem_we && (count == CW'(k))) begin
        hdr[k] <= s_axis_tdata;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mrc_back.sv -----
`default_nettype none
module mrc_back #(
  parameter int FRAME_BYTES = mrc_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            job_empty,
  output logic                                 job_pop,
  input  wire mrc_pkg::job_t                   job,
  output logic                                 mem_re,
  output logic [$clog2(FRAME_BYTES):0]         mem_raddr,
  input  wire logic [7:0]                      mem_rdata,
  output mrc_pkg::done_t                       done,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [mrc_pkg::TDATA_W-1:0]          m_axis_tdata,
  output logic [mrc_pkg::TUSER_W-1:0]          m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int PW = $clog2(FRAME_BYTES);

  mrc_pkg::back_state_t state, state_next;
  mrc_pkg::job_t        cur;
  logic [PW-1:0]        ptr;
  logic [5:0]           idx;
  logic [7:0]           hi;
  logic                 out_valid;
  logic [mrc_pkg::TDATA_W-1:0] out_tdata;
  mrc_pkg::status_t     out_tuser;
  logic                 out_tlast;
  logic                 out_free;
  logic                 load_word;
  logic                 load_status;

  assign out_free = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrc_pkg::BS_IDLE: begin
        if (!job_empty) begin
          state_next = ((job.status == mrc_pkg::ST_READ_OK) && (job.words != 6'd0)) ?
                       mrc_pkg::BS_RD_HI : mrc_pkg::BS_STATUS;
        end
      end
      mrc_pkg::BS_RD_HI: state_next = mrc_pkg::BS_RD_LO;
      mrc_pkg::BS_RD_LO: state_next = mrc_pkg::BS_WORD;
      mrc_pkg::BS_WORD: begin
        if (out_free) begin
          state_next = (idx == (cur.words - 6'd1)) ? mrc_pkg::BS_STATUS : mrc_pkg::BS_RD_HI;
        end
      end
      mrc_pkg::BS_STATUS: begin
        if (out_free) begin
          state_next = mrc_pkg::BS_IDLE;
        end
      end
      default: state_next = mrc_pkg::BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop     = 1'b0;
    mem_re      = 1'b0;
    load_word   = 1'b0;
    load_status = 1'b0;
    case (state)
      mrc_pkg::BS_IDLE:   job_pop     = !job_empty;
      mrc_pkg::BS_RD_HI:  mem_re      = 1'b1;
      mrc_pkg::BS_RD_LO:  mem_re      = 1'b1;
      mrc_pkg::BS_WORD:   load_word   = out_free;
      mrc_pkg::BS_STATUS: load_status = out_free;
      default: ;
    endcase
  end

  assign mem_raddr     = {cur.bank, ptr};
  assign done.valid    = load_status;
  assign done.bank     = cur.bank;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_tdata;
  assign m_axis_tuser  = out_tuser;
  assign m_axis_tlast  = out_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrc_pkg::BS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_word || load_status) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
      ptr <= PW'(3);
      idx <= 6'd0;
    end
    if (mem_re) begin
      ptr <= ptr + PW'(1);
    end
    if (state == mrc_pkg::BS_RD_LO) begin
      hi <= mem_rdata;
    end
    if (load_word) begin
      out_tdata <= {1'b0, 1'b1, idx, hi, mem_rdata, 8'h00};
      out_tuser <= mrc_pkg::ST_DATA;
      out_tlast <= 1'b0;
      idx       <= idx + 6'd1;
    end
    if (load_status) begin
      out_tdata <= {1'b0, cur.closes, 6'd0, 16'h0000, cur.exc_code};
      out_tuser <= cur.status;
      out_tlast <= 1'b1;
    end
  end

  a_word_of_read: assert property (@(posedge clk) disable iff (rst)
    (state == mrc_pkg::BS_WORD) |-> ((cur.status == mrc_pkg::ST_READ_OK) && (idx < cur.words)))
    else $error("data word walk outside a good read");
  a_ptr_tracks_idx: assert property (@(posedge clk) disable iff (rst)
    (state == mrc_pkg::BS_RD_HI) |-> (ptr == (PW'(3) + PW'({idx, 1'b0}))))
    else $error("read pointer out of step with word index");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import mrc_pkg::*;

  // Give up after this many cycles in which no channel completes a transaction
  localparam int STALL_LIMIT = 4000;
  // Cycles to let the block settle once nothing is owed (check plus output pipe)
  localparam int SETTLE_CYCLES = 16;
  // Cycles to watch for stray output after the last result (longest read walk)
  localparam int TAIL_CYCLES = 200;

  // One result item as it should leave the block
  typedef struct packed {
    status_t     status;
    logic [7:0]  exc;
    logic [15:0] word;
    logic [5:0]  idx;
    logic        closes;
    logic        last;
  } verdict_t;

  // One directed frame; a typed verdict replaces the predicted one where set
  typedef struct packed {
    logic [3:0]      len;
    logic [0:7][7:0] b;
    logic            add_crc;
    logic            typed;
    status_t         st;
    logic [7:0]      exc;
    logic            closes;
  } dir_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'h00;   // [7:0] rx_byte
  logic                  s_axis_tlast  = 1'b0;    // end_of_frame
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] exception_code, [23:8] data_word, [29:24] word_index, [30] closes_request, [31] zero
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [TUSER_W-1:0]    m_axis_tuser;            // [3:0] status
  logic                  m_axis_tlast;

  modbus_rtu_reply_checker_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Reply predictor: own copy of the frame buffer, CRC and request registers
  // ---------------------------------------------------------------------------
  logic [7:0]  frame_mem [FRAME_BYTES_DEF];
  int unsigned nbytes   = 0;
  logic [15:0] crc_acc  = CRC_INIT;
  bit          overrun  = 1'b0;

  logic [7:0]  want_dev = 8'd1;
  logic [7:0]  want_fn  = FN_READ_HOLDING;
  logic [15:0] want_reg = 16'd1;
  logic [5:0]  want_cnt = 6'd1;
  logic [15:0] want_val = 16'd0;

  verdict_t frame_verdicts[$];   // verdicts of the frame just closed
  verdict_t verdicts_due[$];     // verdicts still owed by the block
  logic [7:0] tx_frame[$];       // frame being sent
  bit       use_typed = 1'b0;
  verdict_t typed_item;

  int src_gap_pct   = 0;         // chance the sender idles in a cycle
  int sink_hold_pct = 0;         // chance the receiver stalls in a cycle
  int mismatches    = 0;
  int stall_run     = 0;

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Seal the frame: CRC low byte first, so the residue over the whole frame is zero
  function automatic void append_crc();
    logic [15:0] c = CRC_INIT;
    foreach (tx_frame[i]) c = crc16_step(c, tx_frame[i]);
    tx_frame.push_back(c[7:0]);
    tx_frame.push_back(c[15:8]);
  endfunction

  function automatic void add_verdict(status_t s, logic [7:0] e, logic [15:0] w,
                                      logic [5:0] i, logic c, logic l);
    frame_verdicts.push_back('{status: s, exc: e, word: w, idx: i, closes: c, last: l});
  endfunction

  // Store one byte; on the frame end judge the frame in the block's check order
  task automatic absorb_byte(input logic [7:0] b, input logic eof);
    logic [7:0]  cmd;
    int unsigned words;
    logic [15:0] addr1, echo, goal;
    bit          ack_ok;
    frame_verdicts.delete();
    if (nbytes < FRAME_BYTES_DEF) begin
      frame_mem[nbytes] = b;
      nbytes++;
      crc_acc = crc16_step(crc_acc, b);
    end else begin
      overrun = 1'b1;   // drop the byte and spoil the frame
    end
    if (!eof) return;
    cmd = frame_mem[1] & CMD_MASK;
    if (nbytes <= 4) begin
      add_verdict(ST_TOO_SHORT, 8'h00, 16'h0, 6'd0, 1'b0, 1'b1);
    end else if (overrun || crc_acc != 16'h0) begin
      add_verdict(ST_CRC_BAD, 8'h00, 16'h0, 6'd0, 1'b0, 1'b1);
    end else if (frame_mem[0] != want_dev) begin
      add_verdict(ST_DEV_MISMATCH, 8'h00, 16'h0, 6'd0, 1'b0, 1'b1);
    end else if (cmd != want_fn) begin
      add_verdict(ST_FUNC_MISMATCH, 8'h00, 16'h0, 6'd0, 1'b0, 1'b1);
    end else if (frame_mem[1][EXC_BIT]) begin
      add_verdict(ST_EXCEPTION, frame_mem[2], 16'h0, 6'd0, 1'b1, 1'b1);
    end else if (cmd == FN_READ_HOLDING || cmd == FN_READ_INPUT) begin
      // low bit of the byte count is ignored
      words = frame_mem[2] >> 1;
      if (words != want_cnt || words > MAX_WORDS_DEF || nbytes < 5 + 2 * words) begin
        add_verdict(ST_COUNT_MISMATCH, 8'h00, 16'h0, 6'd0, 1'b1, 1'b1);
      end else begin
        for (int i = 0; i < words; i++)
          add_verdict(ST_DATA, 8'h00, {frame_mem[3 + 2 * i], frame_mem[4 + 2 * i]},
                      6'(i), 1'b1, 1'b0);
        add_verdict(ST_READ_OK, 8'h00, 16'h0, 6'd0, 1'b1, 1'b1);
      end
    end else if (cmd == FN_WRITE_SINGLE || cmd == FN_WRITE_MULTI) begin
      ack_ok = 1'b0;
      if (nbytes >= 8) begin
        // echoed address plus one wraps at 16 bits
        addr1  = {frame_mem[2], frame_mem[3]} + 16'd1;
        echo   = {frame_mem[4], frame_mem[5]};
        goal   = (cmd == FN_WRITE_SINGLE) ? want_val : {10'd0, want_cnt};
        ack_ok = (addr1 == want_reg) && (echo == goal);
      end
      add_verdict(ack_ok ? ST_WRITE_OK : ST_ACK_MISMATCH, 8'h00, 16'h0, 6'd0, 1'b1, 1'b1);
    end else begin
      // matched, but not a function the checker knows
      add_verdict(ST_FUNC_MISMATCH, 8'h00, 16'h0, 6'd0, 1'b1, 1'b1);
    end
    nbytes  = 0;
    crc_acc = CRC_INIT;
    overrun = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Present one byte, idling first at random; predict once the transaction completes
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    absorb_byte(b, eof);
    if (eof) begin
      if (use_typed) verdicts_due.push_back(typed_item);
      else foreach (frame_verdicts[i]) verdicts_due.push_back(frame_verdicts[i]);
    end
  endtask

  task automatic push_frame();
    foreach (tx_frame[i]) push_byte(tx_frame[i], i == tx_frame.size() - 1);
  endtask

  // Hold cfg_valid high across back-to-back writes; the caller drops it afterwards
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEVICE:   want_dev = val[7:0];
      CFG_FUNCTION: want_fn  = val[7:0];
      CFG_REGISTER: want_reg = val;
      CFG_COUNT:    want_cnt = val[5:0];
      CFG_VALUE:    want_val = val;
      default: ;
    endcase
  endtask

  // Stop sending and wait until every owed result has left, then let the block settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Randomize the receiver's readiness every cycle
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= sink_hold_pct);

  // ---------------------------------------------------------------------------
  // Result monitor and watchdog
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    verdict_t due;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got status %0d data %h last %b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          due = verdicts_due.pop_front();
          check_field("status",         16'(due.status), 16'(m_axis_tuser));
          check_field("exception_code", 16'(due.exc),    16'(m_axis_tdata[7:0]));
          check_field("data_word",      due.word,        m_axis_tdata[23:8]);
          check_field("word_index",     16'(due.idx),    16'(m_axis_tdata[29:24]));
          check_field("closes_request", 16'(due.closes), 16'(m_axis_tdata[30]));
          check_field("pad bit",        16'h0,           16'(m_axis_tdata[31]));
          check_field("last",           16'(due.last),   16'(m_axis_tlast));
        end
      end
      // Count cycles with no transaction on any channel
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stall_run = 0;
      else
        stall_run++;
      if (stall_run >= STALL_LIMIT) begin
        $display("%0t watchdog: no transaction in %0d cycles", $time, STALL_LIMIT);
        $display("tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  dir_frame_t dir_tab [6];

  // Request settings per phase; the last phase draws its own
  logic [7:0]  ph_dev [8] = '{8'h11, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h00};
  logic [7:0]  ph_fn  [8] = '{FN_READ_HOLDING, FN_READ_INPUT, FN_WRITE_SINGLE, FN_WRITE_MULTI,
                              FN_READ_HOLDING, 8'd7, 8'hFF, FN_READ_HOLDING};
  logic [15:0] ph_reg [8] = '{16'h0100, 16'h0001, 16'h0000, 16'hFFFF,
                              16'h8000, 16'h0002, 16'h0003, 16'h0000};
  logic [5:0]  ph_cnt [8] = '{6'd2, 6'd0, 6'd5, 6'd63, 6'd63, 6'd3, 6'd1, 6'd0};
  logic [15:0] ph_val [8] = '{16'h1234, 16'h0000, 16'hFFFF, 16'hA5A5,
                              16'h0001, 16'h0000, 16'h0007, 16'h0000};
  int          ph_budget [8] = '{1, 6, 6, 6, 1, 6, 6, 6};

  initial begin
    int          r, k, nw, sent, nframe;
    logic [7:0]  bc, devb, fnb, cmd, dv, fv;
    logic [15:0] w16, rv, vv;
    logic [5:0]  cv;

    // Directed frames under the reset settings (device 1, function 3, count 1)
    dir_tab[0] = '{4'd1, 64'h00, 1'b0, 1'b1, ST_TOO_SHORT, 8'h00, 1'b0};
    dir_tab[1] = '{4'd4, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b1, ST_TOO_SHORT, 8'h00, 1'b0};
    dir_tab[2] = '{4'd5, 64'h0103_02FF_0000_0000, 1'b0, 1'b0, ST_CRC_BAD, 8'h00, 1'b0};
    dir_tab[3] = '{4'd5, 64'h0103_02AB_CD00_0000, 1'b1, 1'b0, ST_READ_OK, 8'h00, 1'b1};
    dir_tab[4] = '{4'd3, 64'h0183_0400_0000_0000, 1'b1, 1'b1, ST_EXCEPTION, 8'h04, 1'b1};
    dir_tab[5] = '{4'd3, 64'h0203_0000_0000_0000, 1'b1, 1'b1, ST_DEV_MISMATCH, 8'h00, 1'b0};

    // Hold reset, then release it for good
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[f]) begin
      tx_frame.delete();
      for (k = 0; k < dir_tab[f].len; k++) tx_frame.push_back(dir_tab[f].b[k]);
      if (dir_tab[f].add_crc) append_crc();
      use_typed  = dir_tab[f].typed;
      typed_item = '{status: dir_tab[f].st, exc: dir_tab[f].exc, word: 16'h0, idx: 6'd0,
                     closes: dir_tab[f].closes, last: 1'b1};
      push_frame();
    end
    use_typed = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      // Drain everything before touching the registers
      quiesce();
      case (ph % 4)
        0: begin src_gap_pct = 0;  sink_hold_pct = 0;  end
        1: begin src_gap_pct = 83; sink_hold_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_hold_pct = 83; end
        default: begin src_gap_pct = 10; sink_hold_pct = 10; end
      endcase
      dv = ph_dev[ph];
      fv = ph_fn[ph];
      rv = ph_reg[ph];
      cv = ph_cnt[ph];
      vv = ph_val[ph];
      if (ph == 7) begin
        dv = 8'($urandom);
        case ($urandom_range(3))
          0: fv = FN_READ_HOLDING;
          1: fv = FN_READ_INPUT;
          2: fv = FN_WRITE_SINGLE;
          default: fv = FN_WRITE_MULTI;
        endcase
        rv = 16'($urandom);
        cv = 6'($urandom_range(6));
        vv = 16'($urandom);
      end
      // Fill the unused upper data bits with junk; the block must mask them
      set_register(CFG_DEVICE,   {8'($urandom), dv});
      set_register(CFG_FUNCTION, {8'($urandom), fv});
      set_register(CFG_REGISTER, rv);
      set_register(CFG_COUNT,    {10'($urandom), cv});
      set_register(CFG_VALUE,    vv);
      // An index past the register list must change nothing
      set_register(CFG_VALUE + 3'($urandom_range(1, 3)), 16'($urandom));
      cfg_valid <= 1'b0;

      sent   = 0;
      nframe = 0;
      while (sent < ph_budget[ph]) begin
        tx_frame.delete();
        // Open the widest read with a well-formed frame
        r = (ph == 4 && nframe == 0) ? 99 : $urandom_range(99);
        if (ph == 0 && nframe == 0) begin
          // Run past the buffer: the dropped bytes must spoil the frame
          repeat (FRAME_BYTES_DEF + 2) tx_frame.push_back(8'($urandom));
        end else if (r < 8) begin
          // Line noise, sealed half the time
          repeat ($urandom_range(1, 12)) tx_frame.push_back(8'($urandom));
          if (r < 4) append_crc();
        end else begin
          devb = (r < 14) ? 8'($urandom) : want_dev;
          fnb  = (r >= 14 && r < 20) ? 8'($urandom) : want_fn;
          cmd  = fnb & CMD_MASK;
          tx_frame.push_back(devb);
          if (r >= 20 && r < 28) begin
            // Exception reply
            tx_frame.push_back(fnb | 8'h80);
            tx_frame.push_back(8'($urandom));
          end else begin
            tx_frame.push_back(fnb);
            if (cmd == FN_READ_HOLDING || cmd == FN_READ_INPUT) begin
              bc = {1'b0, want_cnt, 1'($urandom_range(1))};
              if (r >= 28 && r < 34) bc = 8'($urandom);
              nw = bc >> 1;
              if (nw > MAX_WORDS_DEF) nw = MAX_WORDS_DEF;
              // Short payload: fewer words than the byte count claims
              if (r >= 34 && r < 40 && nw > 0) nw = $urandom_range(nw - 1);
              tx_frame.push_back(bc);
              repeat (2 * nw)
                tx_frame.push_back(($urandom_range(3) == 0) ? {8{1'($urandom_range(1))}}
                                                            : 8'($urandom));
            end else if (cmd == FN_WRITE_SINGLE || cmd == FN_WRITE_MULTI) begin
              w16 = want_reg - 16'd1;
              if (r >= 28 && r < 34) w16 = 16'($urandom);
              tx_frame.push_back(w16[15:8]);
              tx_frame.push_back(w16[7:0]);
              w16 = (cmd == FN_WRITE_SINGLE) ? want_val : {10'd0, want_cnt};
              if (r >= 34 && r < 40) w16 = w16 ^ (16'd1 << $urandom_range(15));
              tx_frame.push_back(w16[15:8]);
              tx_frame.push_back(w16[7:0]);
              // Short echo: cut into the address and value
              if (r >= 40 && r < 46) repeat ($urandom_range(1, 4)) void'(tx_frame.pop_back());
            end else begin
              repeat ($urandom_range(6)) tx_frame.push_back(8'($urandom));
            end
          end
          append_crc();
          // Corrupt one byte after sealing
          if (r >= 46 && r < 54) begin
            k = $urandom_range(tx_frame.size() - 1);
            tx_frame[k] = tx_frame[k] ^ 8'($urandom_range(1, 255));
          end
        end
        sent += tx_frame.size();
        nframe++;
        push_frame();
      end
    end

    // Drain, then watch for anything stray before the verdict
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
